>>> rtl/tks_pkg.sv
package tks_pkg;

   localparam int MAX_KEPT    = 16;
   localparam int MAX_CLASSES = 4096;

   localparam int SCORE_W = 32;
   localparam int POS_W   = $clog2(MAX_CLASSES);
   localparam int CSR_W   = 5;
   localparam int KEEP_W  = $clog2(MAX_KEPT + 1);

   localparam logic [CSR_W-1:0] TOP_COUNT_RESET = CSR_W'(5);

   typedef struct packed {
      logic signed [SCORE_W-1:0] score;
      logic                      frame_end;
   } req_type;

   typedef struct packed {
      logic [11:0]               class_position;
      logic signed [SCORE_W-1:0] class_score;
      logic                      run_last;
   } rsp_type;

   // contents of one list slot
   typedef struct packed {
      logic                      valid;
      logic signed [SCORE_W-1:0] score;
      logic [POS_W-1:0]          position;
   } entry_type;

   // broadcast to every slot of the chain
   typedef struct packed {
      logic                      insert;
      logic                      shift_up;
      logic signed [SCORE_W-1:0] score;
      logic [POS_W-1:0]          position;
   } cell_ctrl_type;

endpackage

>>> rtl/top_k_score_selector.sv
// a request without frame_end is absorbed into the cell chain; ready stays high for the next one
// throughput: 1 request per cycle unless draining, set by the cell chain's compare-and-shift
// frame_end: sets the drain flag; then 1 result per cycle while rsp_ready is high (n results)
// the chain drains through the output register; requests resume once the list is empty
// reset (synchronous, active high): empties the list, clears the position counter and the
// output valid flag, and loads top_count with 5; output data and list storage are not cleared
module top_k_score_selector (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  tks_pkg::req_type             req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output tks_pkg::rsp_type             rsp_data,
   input  logic                         csr_wr_en,
   input  logic [tks_pkg::CSR_W-1:0]    csr_wr_data
);
   import tks_pkg::*;

   logic [CSR_W-1:0]  top_count_ff;
   logic [KEEP_W-1:0] keep_count;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              drain_ff, drain_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;
   logic              req_fire, drain_step;
   cell_ctrl_type     ctrl;

   entry_type         entries [0:MAX_KEPT];
   logic              ges     [0:MAX_KEPT-1];
   logic [MAX_KEPT:0] valid_vec;

   assign req_ready  = !drain_ff;
   assign req_fire   = req_valid && req_ready;
   assign drain_step = drain_ff && (!rsp_valid_ff || rsp_ready);

   // clamp the kept count to 1..MAX_KEPT
   always_comb begin
      if (32'(top_count_ff) > 32'(MAX_KEPT)) begin
         keep_count = KEEP_W'(MAX_KEPT);
      end else if (top_count_ff == '0) begin
         keep_count = KEEP_W'(1);
      end else begin
         keep_count = KEEP_W'(top_count_ff);
      end
   end

   assign ctrl.insert   = req_fire;
   assign ctrl.shift_up = drain_step;
   assign ctrl.score    = req_data.score;
   assign ctrl.position = pos_ff;

   // empty slot past the tail feeds the chain while it drains
   assign entries[MAX_KEPT] = '0;

   for (genvar i = 0; i < MAX_KEPT; i++) begin : g_cell
      entry_type prev_entry;
      logic      prev_ge;
      logic      in_bound;

      if (i == 0) begin : g_head
         assign prev_entry = '0;
         assign prev_ge    = 1'b1;
      end else begin : g_body
         assign prev_entry = entries[i-1];
         assign prev_ge    = ges[i-1];
      end

      assign in_bound = 32'(i) < 32'(keep_count);

      tks_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .in_bound   (in_bound),
         .prev_entry (prev_entry),
         .prev_ge    (prev_ge),
         .next_entry (entries[i+1]),
         .entry      (entries[i]),
         .ge         (ges[i])
      );
   end

   always_comb begin
      for (int i = 0; i <= MAX_KEPT; i++) begin
         valid_vec[i] = entries[i].valid;
      end
   end

   always_comb begin
      pos_in = pos_ff;
      if (req_fire) begin
         if (req_data.frame_end || (pos_ff == POS_W'(MAX_CLASSES - 1))) begin
            pos_in = '0;
         end else begin
            pos_in = pos_ff + POS_W'(1);
         end
      end
   end

   always_comb begin
      drain_in     = drain_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (drain_step) begin
         rsp_valid_in          = 1'b1;
         rsp_in.class_position = 12'(entries[0].position);
         rsp_in.class_score    = entries[0].score;
         rsp_in.run_last       = !entries[1].valid;
         if (!entries[1].valid) begin
            drain_in = 1'b0;
         end
      end
      if (req_fire && req_data.frame_end) begin
         drain_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_count_ff <= TOP_COUNT_RESET;
         pos_ff       <= '0;
         drain_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            top_count_ff <= csr_wr_data;
         end
         pos_ff       <= pos_in;
         drain_ff     <= drain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTH
   // list occupancy is always a run of valid slots from the head
   a_thermometer: assert property (@(posedge clock) disable iff (reset)
      ((valid_vec & (valid_vec + (MAX_KEPT+1)'(1))) == '0))
      else $error("list slots are not contiguous");

   // while draining, the head slot always holds an entry
   a_drain_head: assert property (@(posedge clock) disable iff (reset)
      drain_ff |-> entries[0].valid)
      else $error("drain with empty head slot");

   // a frame end starts a drain on the next cycle
   a_frame_end_drain: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_data.frame_end) |=> drain_ff)
      else $error("frame end did not start a drain");

   // the counter is back at zero after a frame end
   a_pos_clear: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_data.frame_end) |=> (pos_ff == '0))
      else $error("position counter not cleared at frame end");
`endif

endmodule

>>> rtl/tks_cell.sv
module tks_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  tks_pkg::cell_ctrl_type ctrl,
   input  logic                  in_bound,
   input  tks_pkg::entry_type    prev_entry,
   input  logic                  prev_ge,
   input  tks_pkg::entry_type    next_entry,
   output tks_pkg::entry_type    entry,
   output logic                  ge
);
   import tks_pkg::*;

   logic                      valid_ff, valid_in;
   logic signed [SCORE_W-1:0] score_ff, score_in;
   logic [POS_W-1:0]          pos_ff, pos_in;

   // held entry ranks ahead of the incoming score (ties keep the older one)
   assign ge = valid_ff && in_bound && (score_ff >= ctrl.score);

   always_comb begin
      valid_in = valid_ff;
      score_in = score_ff;
      pos_in   = pos_ff;
      if (ctrl.insert) begin
         if (ge) begin
            valid_in = 1'b1;
         end else if (prev_ge) begin
            valid_in = in_bound;
            score_in = ctrl.score;
            pos_in   = ctrl.position;
         end else begin
            valid_in = prev_entry.valid && in_bound;
            score_in = prev_entry.score;
            pos_in   = prev_entry.position;
         end
      end else if (ctrl.shift_up) begin
         valid_in = next_entry.valid;
         score_in = next_entry.score;
         pos_in   = next_entry.position;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      score_ff <= score_in;
      pos_ff   <= pos_in;
   end

   assign entry.valid    = valid_ff;
   assign entry.score    = score_ff;
   assign entry.position = pos_ff;

endmodule
